[hdl/modular_exponentiation_core_macros.svh]
// ----------------------------------------------------------------------------
// modular_exponentiation_core_macros.svh
// Assertion macros shared by the modular exponentiation checkers.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define MEXP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types for the modular exponentiation core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mexp_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_REDUCE = 5'b00100,
    S_LOOP   = 5'b01000,
    S_MUL    = 5'b10000
  } mexp_state_t;

  // Status of one bit-serial modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mexp_mul_stat_t;

endpackage

[hdl/mexp_mulmod.sv]
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: r = a * b mod m, one bit of b per cycle,
// MSB first. Needs a < m and m != 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mexp_mulmod
  import mexp_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] a,
  input  logic [OPERAND_WIDTH-1:0] b,
  input  logic [OPERAND_WIDTH-1:0] m,
  output mexp_mul_stat_t           stat,
  output logic [OPERAND_WIDTH-1:0] r
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  a_r, m_r, b_r, r_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;

  // 2r + a < 3m: pick s, s - m or s - 2m by the borrows.
  logic [W+2:0] sum_w, d1_w, d2_w;
  logic [W-1:0] r_nxt;

  always_comb begin
    sum_w = {2'b00, r_r, 1'b0} + (b_r[W-1] ? {3'b000, a_r} : '0);
    d1_w  = sum_w - {3'b000, m_r};
    d2_w  = sum_w - {2'b00, m_r, 1'b0};
    if (!d2_w[W+2]) begin
      r_nxt = d2_w[W-1:0];
    end else if (!d1_w[W+2]) begin
      r_nxt = d1_w[W-1:0];
    end else begin
      r_nxt = sum_w[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      m_r <= m;
      b_r <= b;
      r_r <= '0;
    end else if (busy_r) begin
      r_r <= r_nxt;
      b_r <= {b_r[W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign r         = r_r;

endmodule

[hdl/modular_exponentiation_core.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Right-to-left square and multiply: base ** exponent mod modulus.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive in_* and raise start; the item is taken at the
//   clock edge where start is high and busy is low. busy stays high until
//   the result is issued.
//   Result channel: out_power_result is valid for exactly one cycle while
//   out_valid is high. The receiver cannot stall; it must take it then.
//   Exponent zero or modulus zero: the check state issues the result with
//   no multiply. Otherwise unit B first reduces the base, then for each
//   exponent bit up to the top set one a square and a multiply run, the
//   product kept when the bit is set. One item at a time; a new one may
//   be taken in the strobe cycle.
//   The bit-serial multipliers take one multiplier bit per cycle; the
//   square and the multiply of each exponent bit run side by side on two
//   units.
//   Reset (rst_n low, synchronous) returns to idle and drops any item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modular_exponentiation_core
  import mexp_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_base_value,
  input  logic [31:0] in_exponent_value,
  input  logic [31:0] in_modulus_value,
  output logic        out_valid,
  output logic [31:0] out_power_result
);

  localparam int W = OPERAND_WIDTH;

  mexp_state_t state_r, state_nxt;

  // Operand registers, W bits wide.
  logic [W-1:0] base_r, expo_r, mod_r, acc_r;
  logic         out_valid_r;
  logic [31:0]  out_res_r;

  // Ports are 32 bits; widen with zeros, then keep the low W bits.
  logic [W+31:0] base_ext, expo_ext, mod_ext, acc_ext;
  assign base_ext = {{W{1'b0}}, in_base_value};
  assign expo_ext = {{W{1'b0}}, in_exponent_value};
  assign mod_ext  = {{W{1'b0}}, in_modulus_value};
  assign acc_ext  = {32'd0, acc_r};

  // 1 mod m: zero when m is one.
  logic [W-1:0] one_mod;
  assign one_mod = (mod_r == W'(1)) ? '0 : W'(1);

  // Unit A: acc * base. Unit B: base * base, or the initial base mod m
  // done as (1 mod m) * base.
  mexp_mul_stat_t mul_a_st, mul_b_st;
  logic [W-1:0]   mul_a_r, mul_b_r, mul_b_a;
  logic           start_a, start_b;

  assign mul_b_a = (state_r == S_CHECK) ? one_mod : base_r;

  mexp_mulmod #(.OPERAND_WIDTH(W)) u_mul_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_a),
    .a     (acc_r),
    .b     (base_r),
    .m     (mod_r),
    .stat  (mul_a_st),
    .r     (mul_a_r)
  );

  mexp_mulmod #(.OPERAND_WIDTH(W)) u_mul_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_b),
    .a     (mul_b_a),
    .b     (base_r),
    .m     (mod_r),
    .stat  (mul_b_st),
    .r     (mul_b_r)
  );

  logic accept;
  logic mul_done;
  assign accept   = start && (state_r == S_IDLE);
  // In the loop both units start together and run the same count.
  assign mul_done = mul_b_st.done && !mul_a_st.busy;

  always_comb begin
    state_nxt = state_r;
    start_a   = 1'b0;
    start_b   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (expo_r == '0 || mod_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          start_b   = 1'b1;
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (mul_b_st.done) state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (expo_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          start_a   = 1'b1;
          start_b   = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) state_nxt = S_LOOP;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= ((state_r == S_CHECK) && (expo_r == '0 || mod_r == '0)) ||
                     ((state_r == S_LOOP) && (expo_r == '0));
    end
  end

  // Datapath: no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      base_r <= base_ext[W-1:0];
      expo_r <= expo_ext[W-1:0];
      mod_r  <= mod_ext[W-1:0];
    end
    case (state_r)
      S_CHECK: begin
        acc_r <= one_mod;
        // Exponent zero wins over modulus zero.
        out_res_r <= (expo_r == '0) ? 32'd1 : 32'd0;
      end
      S_REDUCE: begin
        if (mul_b_st.done) base_r <= mul_b_r;
      end
      S_LOOP: begin
        out_res_r <= acc_ext[31:0];
      end
      S_MUL: begin
        if (mul_done) begin
          if (expo_r[0]) acc_r <= mul_a_r;
          base_r <= mul_b_r;
          expo_r <= {1'b0, expo_r[W-1:1]};
        end
      end
      default: ;
    endcase
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_power_result = out_res_r;

endmodule

[hdl/mexp_checker.sv]
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks on the modular exponentiation core, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modular_exponentiation_core_macros.svh"

module mexp_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // An accepted item keeps the core busy.
  `MEXP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after accept")
  // A result only follows work in progress.
  `MEXP_ASSERT_NOW(a_res_after_busy, out_valid, $past(busy), "result with no item")
  // Core is idle again when the result shows.
  `MEXP_ASSERT_NOW(a_res_idle, out_valid, !busy, "busy during result strobe")
  // One strobe per item.
  `MEXP_ASSERT_NEXT(a_res_single, out_valid, !out_valid, "result strobe repeated")

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for modular_exponentiation_core. Directed commands come
// first, then random bursts; each one is predicted by square-and-multiply with
// full-width products. Every strobed result is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Holds the predicted powers in issue order and checks each strobed result.
class power_scoreboard;
  bit [31:0]   pending_powers[$];
  int unsigned items_noted;
  int unsigned results_checked;
  int unsigned zero_exponent_items;
  int unsigned unit_modulus_items;
  int unsigned failures;

  // base ** exponent mod modulus, right to left, products at 64 bits.
  function automatic bit [31:0] mod_power(bit [31:0] base_val, bit [31:0] expo_val,
                                          bit [31:0] mod_val);
    bit [63:0] acc;
    bit [63:0] sq;
    bit [31:0] bits_left;
    if (expo_val == 0) return 32'd1;      // unreduced, even for modulus one
    if (mod_val == 0) return 32'd0;
    sq = base_val % mod_val;
    acc = 64'd1 % mod_val;
    bits_left = expo_val;
    while (bits_left != 0) begin
      if (bits_left[0]) acc = (acc * sq) % mod_val;
      sq = (sq * sq) % mod_val;
      bits_left = bits_left >> 1;
    end
    return acc[31:0];
  endfunction

  function void note_item(bit [31:0] base_val, bit [31:0] expo_val, bit [31:0] mod_val);
    pending_powers.push_back(mod_power(base_val, expo_val, mod_val));
    items_noted++;
    if (expo_val == 0) zero_exponent_items++;
    if (mod_val == 1) unit_modulus_items++;
  endfunction

  function void check_result(bit [31:0] actual);
    bit [31:0] predicted;
    if (pending_powers.size() == 0) begin
      $error("power_result: unexpected item, actual 0x%08h", actual);
      failures++;
      return;
    end
    predicted = pending_powers.pop_front();
    results_checked++;
    if (actual !== predicted) begin
      $error("power_result: expected 0x%08h, actual 0x%08h", predicted, actual);
      failures++;
    end
  endfunction

  function void check_drained();
    if (pending_powers.size() != 0) begin
      $error("power_result: %0d expected items never arrived", pending_powers.size());
      failures++;
    end
  endfunction
endclass

module testbench;

  // The limit covers every item at full exponent length plus the longest
  // idle gaps, several times over.
  localparam int unsigned RANDOM_ITEMS = 270;
  localparam int unsigned DRAIN_CYCLES = 1200;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_base_value;
  logic [31:0] in_exponent_value;
  logic [31:0] in_modulus_value;
  logic        out_valid;
  logic [31:0] out_power_result;

  int unsigned     cycle_count = 0;
  power_scoreboard sb = new();

  modular_exponentiation_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_base_value     (in_base_value),
    .in_exponent_value (in_exponent_value),
    .in_modulus_value  (in_modulus_value),
    .out_valid         (out_valid),
    .out_power_result  (out_power_result)
  );

  // 20 ns clock.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Run guard: a hung core or a lost strobe ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: the core strobes each result for one cycle, no back-pressure.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_result(out_power_result);
  end

  // Present one command at the falling edge and hold it until the core takes
  // it (start high, busy low at a rising edge). start stays high afterwards;
  // the next call or idle_for decides its value at the next falling edge.
  task automatic send_item(input bit [31:0] base_val, input bit [31:0] expo_val,
                           input bit [31:0] mod_val);
    @(negedge clk);
    start             <= 1'b1;
    in_base_value     <= base_val;
    in_exponent_value <= expo_val;
    in_modulus_value  <= mod_val;
    forever begin
      @(posedge clk);
      if (busy === 1'b0) break;
    end
    sb.note_item(base_val, expo_val, mod_val);
  endtask

  // Sender gap of a given number of cycles with start low.
  task automatic idle_for(input int unsigned cycles);
    @(negedge clk);
    start <= 1'b0;
    if (cycles > 1) repeat (cycles - 1) @(negedge clk);
  endtask

  initial begin
    int unsigned burst_left;
    int unsigned nbits;
    bit [31:0]   base_val;
    bit [31:0]   expo_val;
    bit [31:0]   mod_val;

    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_base_value     <= '0;
    in_exponent_value <= '0;
    in_modulus_value  <= '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    idle_for(2);

    // Directed: exponent zero (even with modulus one), modulus one, operand
    // extremes, base at and above the modulus, small and power-of-two moduli.
    send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    send_item(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(32'h1234_5678, 32'h0000_0000, 32'h0000_0007);
    send_item(32'h1234_5678, 32'h0000_0005, 32'h0000_0001);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
    send_item(32'h0000_0000, 32'h0000_0005, 32'h0000_000D);
    send_item(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFB);
    send_item(32'hFFFF_FFFA, 32'hFFFF_FFFE, 32'hFFFF_FFFB);
    send_item(32'h0000_0007, 32'h0000_0007, 32'h0000_0007);
    send_item(32'h0000_0003, 32'h0000_0001, 32'h0000_0002);
    send_item(32'h0000_0002, 32'h0000_001F, 32'h8000_0000);
    send_item(32'h0000_0002, 32'h0000_0020, 32'h8000_0000);
    send_item(32'h0000_0003, 32'h8000_0000, 32'h0000_0065);
    send_item(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002);
    send_item(32'hDEAD_BEEF, 32'h0001_0001, 32'hC000_0001);
    send_item(32'h8000_0000, 32'h0000_0002, 32'hFFFF_FFFF);
    idle_for(5);

    // Random bursts. Mostly short gaps, some none, a few longer than an item.
    burst_left = 0;
    repeat (RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        case ($urandom_range(0, 7))
          0, 1:    ;                                  // back to back
          2:       idle_for($urandom_range(25, 1200));
          default: idle_for($urandom_range(1, 24));
        endcase
      end
      burst_left--;

      case ($urandom_range(0, 9))
        0:       mod_val = $urandom_range(1, 255);
        1:       mod_val = 32'd1;
        2:       mod_val = 32'hFFFF_FFFF - $urandom_range(0, 15);
        3:       mod_val = 32'd1 << $urandom_range(0, 31);
        default: mod_val = $urandom;
      endcase
      if (mod_val == 0) mod_val = 32'd1;

      case ($urandom_range(0, 7))
        0:       base_val = 32'd0;
        1:       base_val = 32'hFFFF_FFFF;
        2:       base_val = mod_val - 1;
        3:       base_val = $urandom_range(0, 3);
        default: base_val = $urandom;
      endcase

      // Exponent of random length, top bit set, so latency varies widely.
      nbits = $urandom_range(0, 33);
      if (nbits == 0) expo_val = 32'd0;
      else if (nbits == 33) expo_val = 32'hFFFF_FFFF;
      else expo_val = ($urandom & (32'hFFFF_FFFF >> (32 - nbits))) | (32'd1 << (nbits - 1));

      send_item(base_val, expo_val, mod_val);
    end
    @(negedge clk);
    start <= 1'b0;

    // Drain, then watch a while longer for any stray strobe.
    while (sb.pending_powers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_drained();

    $display("Run: %0d commands issued, %0d results compared in %0d cycles.",
             sb.items_noted, sb.results_checked, cycle_count);
    $display("Of those, %0d had exponent zero and %0d had modulus one.",
             sb.zero_exponent_items, sb.unit_modulus_items);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/mexp_pkg.sv
hdl/mexp_mulmod.sv
hdl/modular_exponentiation_core.sv
hdl/mexp_checker.sv
test/testbench.sv
